### sv/cubic_bezier_flatten_top_macros.svh
// Assertion macros for the cubic Bezier flattener checker.
`ifndef CUBIC_BEZIER_FLATTEN_TOP_MACROS_SVH
`define CUBIC_BEZIER_FLATTEN_TOP_MACROS_SVH

// Same-cycle implication.
`define CBF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CBF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/cbf_pkg.sv
package cbf_pkg;

	localparam int DEF_MAX_SEGMENTS = 64;
	localparam int DEF_COORD_WIDTH  = 16;

	localparam int SEG_W      = 7;
	localparam int T_W        = 17;
	localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;
	localparam int LIMB_W     = 16;
	localparam int LIMB_SEL_W = 2;
	localparam int MULT_A_W   = 17;
	localparam int MULT_B_W   = 33;
	localparam int PROD_W     = MULT_A_W + MULT_B_W;
	localparam int SHIFT_W    = PROD_W + 2 * LIMB_W;
	localparam int W_W        = 49;
	localparam int FRAC_W     = 48;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_SS,
		DST_TT,
		DST_W0,
		DST_W1,
		DST_W2,
		DST_W3,
		DST_ACC
	} dest_t;

	typedef struct packed {
		dest_t                 dest;
		logic [LIMB_SEL_W-1:0] limb;
		logic                  first;
		logic                  fin_x;
		logic                  fin_y;
	} mac_op_t;

endpackage

### sv/cbf_mac.sv
module cbf_mac import cbf_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [MULT_A_W-1:0]    a,
	input  logic [MULT_B_W-1:0]    b,
	input  mac_op_t                op,
	output logic [PROD_W-1:0]      prod,
	output mac_op_t                done_op,
	output logic [COORD_WIDTH-1:0] coord
);

	localparam int ACC_W = FRAC_W + COORD_WIDTH;
	localparam logic [ACC_W-1:0] HALF =
		{{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

	logic [PROD_W-1:0]  prod_s1;
	mac_op_t            op_s1;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   acc_base;
	logic [ACC_W-1:0]   sum;
	logic [SHIFT_W-1:0] shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a) * PROD_W'(b);
		if (op_s1.dest == DST_ACC) begin
			acc_q <= sum;
		end
	end

	always_comb begin
		case (op_s1.limb)
			2'd0: shifted = {{(2*LIMB_W){1'b0}}, prod_s1};
			2'd1: shifted = {{LIMB_W{1'b0}}, prod_s1, {LIMB_W{1'b0}}};
			2'd2: shifted = {prod_s1, {(2*LIMB_W){1'b0}}};
			default: shifted = '0;
		endcase
		acc_base = op_s1.first ? HALF : acc_q;
		sum = acc_base + shifted[ACC_W-1:0];
	end

	assign prod    = prod_s1;
	assign done_op = op_s1;
	assign coord   = sum[FRAC_W +: COORD_WIDTH];

endmodule

### sv/cubic_bezier_flatten_top.sv
// Cubic Bezier flattener.
// Request channel: drive the eight curve coordinates, mode and segments and
// raise start; the request is taken at a rising edge where start is high and
// busy is low. Mode 1 replaces both control points by points on the midline.
// Segments of zero means one, values above MAX_SEGMENTS are saturated.
// Result channel: each curve point appears on point_x, point_y, point_index
// and last for exactly one cycle while valid is high; the receiver cannot
// hold it off. last marks the curve end.
// Sequence: a restoring divide forms 65536/n once, then each point runs
// through one 17x33 multiplier: 6 products for the Bernstein weights, 24
// limb products accumulated per coordinate pair, and 1 drain.
// Points follow one after another; a new one starts only after the drain
// of the one before, and a request keeps busy high until its final point.
// busy drops in the cycle of the final point, when a new request may enter.
// Reset clears the sequencer and the strobe; no point is pending afterward.
module cubic_bezier_flatten_top import cbf_pkg::*; #(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
	parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] ctrl1_x,
	input  logic signed [COORD_WIDTH-1:0] ctrl1_y,
	input  logic signed [COORD_WIDTH-1:0] ctrl2_x,
	input  logic signed [COORD_WIDTH-1:0] ctrl2_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic [SEG_W-1:0]              segments,
	output logic                          valid,
	output logic signed [COORD_WIDTH-1:0] point_x,
	output logic signed [COORD_WIDTH-1:0] point_y,
	output logic [SEG_W-1:0]              point_index,
	output logic                          last
);

	localparam int IDX_W     = $clog2(MAX_SEGMENTS + 1);
	localparam int DIV_CNT_W = $clog2(T_W);
	localparam int DIV_TOP   = T_W - 1;
	localparam logic [1:0] TERM_LAST = 2'd3;
	localparam logic [1:0] LIMB_LAST = 2'd2;

	typedef logic [COORD_WIDTH-1:0] coord_t;
	localparam coord_t SIGN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_TSTEP,
		S_WGT,
		S_BLEND,
		S_DRAIN
	} state_t;

	typedef enum logic [2:0] {
		WS_SS,
		WS_TT,
		WS_W0,
		WS_W3,
		WS_W1,
		WS_W2
	} wstep_t;

	state_t                 state_q;
	wstep_t                 wstep_q;
	logic [IDX_W-1:0]       n_q;
	logic [IDX_W-1:0]       i_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;
	logic [1:0]             limb_q;
	logic [1:0]             term_q;
	logic                   coord_q;
	logic                   valid_q;
	coord_t                 px_q;
	coord_t                 py_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   last_q;

	coord_t                 qx_q [4];
	coord_t                 qy_q [4];
	coord_t                 xr_q;
	logic [IDX_W-1:0]       rem_q;
	logic [IDX_W-1:0]       racc_q;
	logic [T_W-1:0]         q0_q;
	logic [T_W-1:0]         t_q;
	logic [MULT_B_W-1:0]    ss_q;
	logic [MULT_B_W-1:0]    tt_q;
	logic [W_W-1:0]         w_q [4];

	logic                   accept;
	logic                   adv;
	coord_t                 in_qx [4];
	coord_t                 in_qy [4];
	logic [COORD_WIDTH:0]   ysum;
	logic [SEG_W-1:0]       seg_c;
	logic                   dbit;
	logic [IDX_W:0]         rem_sh;
	logic [IDX_W:0]         rem_sub;
	logic                   div_ge;
	logic [IDX_W-1:0]       rem_nx;
	logic [IDX_W:0]         rsum;
	logic [IDX_W:0]         rsub;
	logic                   carry;
	logic [IDX_W-1:0]       racc_nx;
	logic [T_W-1:0]         t_nx;
	logic [T_W-1:0]         s_w;
	logic [W_W-1:0]         w_sel;
	logic [W_W-1:0]         w_x3;
	logic                   blend_end;

	logic [MULT_A_W-1:0]    mac_a;
	logic [MULT_B_W-1:0]    mac_b;
	mac_op_t                mac_op;
	logic [PROD_W-1:0]      mac_prod;
	mac_op_t                mac_done;
	coord_t                 mac_coord;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;

	always_comb begin
		in_qx[0] = coord_t'(start_x) ^ SIGN;
		in_qy[0] = coord_t'(start_y) ^ SIGN;
		in_qx[3] = coord_t'(end_x) ^ SIGN;
		in_qy[3] = coord_t'(end_y) ^ SIGN;
		ysum = {1'b0, in_qy[0]} + {1'b0, in_qy[3]};
		if (mode) begin
			in_qx[1] = in_qx[0];
			in_qy[1] = ysum[COORD_WIDTH:1];
			in_qx[2] = in_qx[3];
			in_qy[2] = ysum[COORD_WIDTH:1];
		end else begin
			in_qx[1] = coord_t'(ctrl1_x) ^ SIGN;
			in_qy[1] = coord_t'(ctrl1_y) ^ SIGN;
			in_qx[2] = coord_t'(ctrl2_x) ^ SIGN;
			in_qy[2] = coord_t'(ctrl2_y) ^ SIGN;
		end
		if (segments == '0) begin
			seg_c = SEG_W'(1);
		end else if (segments > SEG_W'(MAX_SEGMENTS)) begin
			seg_c = SEG_W'(MAX_SEGMENTS);
		end else begin
			seg_c = segments;
		end
	end

	always_comb begin
		dbit    = div_cnt_q == DIV_CNT_W'(DIV_TOP);
		rem_sh  = {rem_q, dbit};
		rem_sub = rem_sh - {1'b0, n_q};
		div_ge  = rem_sh >= {1'b0, n_q};
		rem_nx  = div_ge ? rem_sub[IDX_W-1:0] : rem_sh[IDX_W-1:0];

		rsum    = {1'b0, racc_q} + {1'b0, rem_q};
		rsub    = rsum - {1'b0, n_q};
		carry   = rsum >= {1'b0, n_q};
		racc_nx = carry ? rsub[IDX_W-1:0] : rsum[IDX_W-1:0];
		t_nx    = t_q + q0_q + T_W'(carry);
		s_w     = ONE_Q16 - t_q;

		adv = (state_q == S_TSTEP) || ((state_q == S_DRAIN) && (i_q != n_q));
		blend_end = coord_q && (term_q == TERM_LAST) && (limb_q == LIMB_LAST);
		w_x3 = mac_prod[W_W-1:0] + {mac_prod[W_W-2:0], 1'b0};
	end

	always_comb begin
		mac_a  = '0;
		mac_b  = '0;
		mac_op = '0;
		w_sel  = w_q[term_q];
		case (state_q)
			S_WGT: begin
				case (wstep_q)
					WS_SS: begin
						mac_a = s_w;
						mac_b = MULT_B_W'(s_w);
						mac_op.dest = DST_SS;
					end
					WS_TT: begin
						mac_a = t_q;
						mac_b = MULT_B_W'(t_q);
						mac_op.dest = DST_TT;
					end
					WS_W0: begin
						mac_a = s_w;
						mac_b = ss_q;
						mac_op.dest = DST_W0;
					end
					WS_W3: begin
						mac_a = t_q;
						mac_b = tt_q;
						mac_op.dest = DST_W3;
					end
					WS_W1: begin
						mac_a = t_q;
						mac_b = ss_q;
						mac_op.dest = DST_W1;
					end
					WS_W2: begin
						mac_a = s_w;
						mac_b = tt_q;
						mac_op.dest = DST_W2;
					end
					default: begin
						mac_op.dest = DST_NONE;
					end
				endcase
			end
			S_BLEND: begin
				case (limb_q)
					2'd0: mac_a = {1'b0, w_sel[LIMB_W-1:0]};
					2'd1: mac_a = {1'b0, w_sel[2*LIMB_W-1:LIMB_W]};
					2'd2: mac_a = w_sel[W_W-1:2*LIMB_W];
					default: mac_a = '0;
				endcase
				mac_b = coord_q ? MULT_B_W'(qy_q[term_q]) : MULT_B_W'(qx_q[term_q]);
				mac_op.dest  = DST_ACC;
				mac_op.limb  = limb_q;
				mac_op.first = (term_q == 2'd0) && (limb_q == 2'd0);
				mac_op.fin_x = !coord_q && (term_q == TERM_LAST) && (limb_q == LIMB_LAST);
				mac_op.fin_y = blend_end;
			end
			default: begin
				mac_op.dest = DST_NONE;
			end
		endcase
	end

	cbf_mac #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.a       (mac_a),
		.b       (mac_b),
		.op      (mac_op),
		.prod    (mac_prod),
		.done_op (mac_done),
		.coord   (mac_coord)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			wstep_q   <= WS_SS;
			n_q       <= '0;
			i_q       <= '0;
			div_cnt_q <= '0;
			limb_q    <= '0;
			term_q    <= '0;
			coord_q   <= 1'b0;
			valid_q   <= 1'b0;
			px_q      <= '0;
			py_q      <= '0;
			idx_q     <= '0;
			last_q    <= 1'b0;
		end else begin
			valid_q <= mac_done.fin_y;
			if (mac_done.fin_y) begin
				px_q   <= xr_q ^ SIGN;
				py_q   <= mac_coord ^ SIGN;
				idx_q  <= i_q;
				last_q <= i_q == n_q;
			end
			if (adv) begin
				i_q <= i_q + IDX_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q       <= IDX_W'(seg_c);
						i_q       <= '0;
						div_cnt_q <= DIV_CNT_W'(DIV_TOP);
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
					if (div_cnt_q == '0) begin
						state_q <= S_TSTEP;
					end
				end
				S_TSTEP: begin
					wstep_q <= WS_SS;
					state_q <= S_WGT;
				end
				S_WGT: begin
					if (wstep_q == WS_W2) begin
						limb_q  <= '0;
						term_q  <= '0;
						coord_q <= 1'b0;
						state_q <= S_BLEND;
					end else begin
						wstep_q <= wstep_t'(wstep_q + 3'd1);
					end
				end
				S_BLEND: begin
					if (limb_q == LIMB_LAST) begin
						limb_q <= '0;
						term_q <= term_q + 2'd1;
						if (term_q == TERM_LAST) begin
							coord_q <= 1'b1;
						end
					end else begin
						limb_q <= limb_q + 2'd1;
					end
					if (blend_end) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (i_q == n_q) begin
						state_q <= S_IDLE;
					end else begin
						wstep_q <= WS_SS;
						state_q <= S_WGT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < 4; k++) begin
				qx_q[k] <= in_qx[k];
				qy_q[k] <= in_qy[k];
			end
			rem_q  <= '0;
			racc_q <= '0;
			q0_q   <= '0;
			t_q    <= '0;
		end
		if (state_q == S_DIV) begin
			rem_q <= rem_nx;
			q0_q  <= {q0_q[T_W-2:0], div_ge};
		end
		if (adv) begin
			t_q    <= t_nx;
			racc_q <= racc_nx;
		end
		case (mac_done.dest)
			DST_SS: ss_q <= mac_prod[MULT_B_W-1:0];
			DST_TT: tt_q <= mac_prod[MULT_B_W-1:0];
			DST_W0: w_q[0] <= mac_prod[W_W-1:0];
			DST_W1: w_q[1] <= w_x3;
			DST_W2: w_q[2] <= w_x3;
			DST_W3: w_q[3] <= mac_prod[W_W-1:0];
			default: begin
			end
		endcase
		if (mac_done.fin_x) begin
			xr_q <= mac_coord;
		end
	end

	assign valid       = valid_q;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign point_index = SEG_W'(idx_q);
	assign last        = last_q;

endmodule

### sv/cbf_checker.sv
`include "cubic_bezier_flatten_top_macros.svh"

module cbf_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic valid,
	input logic last
);

	`CBF_ASSERT_NOW(a_mid_busy, valid && !last, busy, "point before curve end without busy")
	`CBF_ASSERT_NOW(a_fall_last, $fell(busy), valid && last, "busy dropped without final point")
	`CBF_ASSERT_NEXT(a_take, start && !busy, busy && !valid, "request not taken up")
	`CBF_ASSERT_NEXT(a_strobe, valid, !valid, "point strobe longer than one cycle")

endmodule

bind cubic_bezier_flatten_top cbf_checker u_cbf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.valid  (valid),
	.last   (last)
);
